FILE: sv/dcnt_pkg.sv
// Shared types and constants for the doorway direction counter.
// No dependencies; imported by every other file in this folder.
package dcnt_pkg;

   localparam int SENSOR_COUNT_DEF   = 4;
   localparam int WARMUP_SAMPLES_DEF = 8;
   localparam int MAX_OCCUPANTS_DEF  = 50;

   // transaction kinds
   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_RECAL  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_TRIGGER  = 3'd0;
   localparam logic [2:0] REG_RELEASE  = 3'd1;
   localparam logic [2:0] REG_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_COOLDOWN = 3'd3;
   localparam logic [2:0] REG_MODE     = 3'd4;
   localparam logic [2:0] REG_INVERT   = 3'd5;

   // row codes
   localparam logic [1:0] ROW_NONE = 2'd0;
   localparam logic [1:0] ROW_A    = 2'd1;
   localparam logic [1:0] ROW_B    = 2'd2;

   // phase codes
   localparam logic [3:0] PH_RECAL      = 4'd0;
   localparam logic [3:0] PH_CALIB      = 4'd1;
   localparam logic [3:0] PH_WAIT_CLEAR = 4'd2;
   localparam logic [3:0] PH_READY      = 4'd3;
   localparam logic [3:0] PH_SETTLE     = 4'd4;
   localparam logic [3:0] PH_A_LEAD     = 4'd5;
   localparam logic [3:0] PH_B_LEAD     = 4'd6;
   localparam logic [3:0] PH_BOTH_IDLE  = 4'd7;
   localparam logic [3:0] PH_TIMEOUT    = 4'd8;
   localparam logic [3:0] PH_BOTH_SEQ   = 4'd9;
   localparam logic [3:0] PH_A_ACTIVE   = 4'd10;
   localparam logic [3:0] PH_B_ACTIVE   = 4'd11;
   localparam logic [3:0] PH_CANCELLED  = 4'd12;
   localparam logic [3:0] PH_COUNTED    = 4'd13;
   localparam logic [3:0] PH_MONITOR    = 4'd14;
   localparam logic [3:0] PH_NO_READING = 4'd15;

   // direction codes
   localparam logic [2:0] DIR_NONE   = 3'd0;
   localparam logic [2:0] DIR_ENTRY  = 3'd1;
   localparam logic [2:0] DIR_EXIT   = 3'd2;
   localparam logic [2:0] DIR_CANCEL = 3'd3;
   localparam logic [2:0] DIR_RESET  = 3'd4;
   localparam logic [2:0] DIR_IDLE   = 3'd5;

   localparam int DIV_STEPS = 16;  // two quotient bits per step

   // per-transaction controls broadcast to the lanes
   typedef struct packed {
      logic [1:0]  kind;
      logic        count_mode;
      logic [15:0] trigger_delta;
      logic [15:0] release_delta;
   } lane_ctl_type;

   // one result transaction
   typedef struct packed {
      logic        ready_res;
      logic        presence;
      logic [2:0]  last_direction;
      logic [3:0]  phase;
      logic        row_b_active;
      logic        row_a_active;
      logic [3:0]  occupied_mask;
      logic [5:0]  occupants;
      logic [31:0] exit_total;
      logic [31:0] entry_total;
   } result_type;

endpackage

FILE: sv/doorway_direction_counter_top.sv
// Top level of the doorway direction counter: stream channels, register
// port, sensor lanes and the merge stage. Depends on dcnt_pkg, dcnt_lane, dcnt_seq.
//
// Usage: one request transaction carries a sensor update, a recalibrate or
// a count-reset command (kind on req_tuser). Each request yields exactly one
// response transaction with the counters, occupancy and phase.
// A taken request passes the occupancy step and then the merge step, which
// registers the response and sets it valid. Requests do not overlap: the next is
// taken only after these and the 16 steps of the per-lane radix-4 baseline divider.
// The divider runs after the response is issued, so it adds no latency.
// Stall: the response sits in an output register; a new request is still
// taken while it waits, and the merge step holds until the slot is free.
// Reset: synchronous, active high; baselines, counters and sequence state clear,
// registers take their defaults. The user writes registers through the csr_ port
// only while the block is idle; the block itself does not enforce this.
module doorway_direction_counter_top #(
   parameter int SENSOR_COUNT   = dcnt_pkg::SENSOR_COUNT_DEF,
   parameter int WARMUP_SAMPLES = dcnt_pkg::WARMUP_SAMPLES_DEF,
   parameter int MAX_OCCUPANTS  = dcnt_pkg::MAX_OCCUPANTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // now_ms[31:0], present_mask[35:32], reading_mask[39:36],
   // distance_0[55:40], distance_1[71:56], distance_2[87:72], distance_3[103:88]
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,   // kind[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_total[31:0], exit_total[63:32], occupants[69:64], occupied_mask[73:70],
   // row_a_active[74], row_b_active[75], phase[79:76], last_direction[82:80],
   // presence[83], ready_res[84], zero fill[87:85]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import dcnt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_OCC, S_BASE, S_DIV} state_type;

   state_type    state_ff;
   logic [3:0]   cnt_ff;
   logic         rv_ff;
   result_type   res_ff;

   logic [15:0]  trig_ff, rel_ff;
   logic [31:0]  tmo_ff, cool_ff;
   logic         mode_ff, inv_ff;

   logic [103:0] data_ff;
   logic [1:0]   kind_ff;

   lane_ctl_type ctl;
   logic [3:0]   lane_exists, pres_eff, lane_occ, lane_vn;
   logic         allow, occ_go, base_go, div_step, div_last;
   result_type   res_next;

   assign ctl.kind          = kind_ff;
   assign ctl.count_mode    = mode_ff;
   assign ctl.trigger_delta = trig_ff;
   assign ctl.release_delta = rel_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) lane_exists[i] = (i < SENSOR_COUNT);
   end
   assign pres_eff = data_ff[35:32] & lane_exists;

   assign req_tready = (state_ff == S_IDLE);
   assign occ_go     = (state_ff == S_OCC);
   assign base_go    = (state_ff == S_BASE) && (!rv_ff || rsp_tready);
   assign div_step   = (state_ff == S_DIV);
   assign div_last   = div_step && cnt_ff == 4'(DIV_STEPS - 1);

   // sensor lanes
   for (genvar g = 0; g < 4; g++) begin : g_lane
      if (g < SENSOR_COUNT) begin : g_on
         dcnt_lane #(.WARMUP_SAMPLES(WARMUP_SAMPLES)) u_lane (
            .clock, .reset, .ctl,
            .present(pres_eff[g]), .reading(data_ff[36 + g]),
            .distance(data_ff[40 + 16*g +: 16]),
            .occ_go, .base_go, .allow, .div_step, .div_last,
            .occupied(lane_occ[g]), .valid_next(lane_vn[g])
         );
      end else begin : g_off
         assign lane_occ[g] = 1'b0;
         assign lane_vn[g]  = 1'b0;
      end
   end

   dcnt_seq #(.MAX_OCCUPANTS(MAX_OCCUPANTS)) u_seq (
      .clock, .reset, .go(base_go), .ctl, .invert(inv_ff),
      .timeout(tmo_ff), .cooldown(cool_ff), .now_ms(data_ff[31:0]),
      .present(pres_eff), .reading(data_ff[39:36]),
      .occ(lane_occ), .valid_next(lane_vn), .allow, .result(res_next)
   );

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'd0, res_ff};

   // control sequencer, output slot and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         trig_ff  <= 16'd100;
         rel_ff   <= 16'd50;
         tmo_ff   <= 32'd3000;
         cool_ff  <= 32'd500;
         mode_ff  <= 1'b1;
         inv_ff   <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready && !base_go) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) state_ff <= S_OCC;
            S_OCC:  state_ff <= S_BASE;
            S_BASE: if (base_go) begin
               rv_ff    <= 1'b1;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (div_last) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_wen) begin
            unique case (csr_index)
               REG_TRIGGER:  trig_ff <= csr_wdata[15:0];
               REG_RELEASE:  rel_ff  <= csr_wdata[15:0];
               REG_TIMEOUT:  tmo_ff  <= csr_wdata;
               REG_COOLDOWN: cool_ff <= csr_wdata;
               REG_MODE:     mode_ff <= csr_wdata[0];
               REG_INVERT:   inv_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
         kind_ff <= req_tuser;
      end
      if (base_go) res_ff <= res_next;
   end

   // accepted request reaches the occupancy phase next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_OCC)
      else $error("request not processed");
   // merge step always produces a response
   assert property (@(posedge clock) disable iff (reset) base_go |=> rsp_tvalid)
      else $error("merge step without response");
   // divider phase leaves only after its full step count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && !div_last |=> state_ff == S_DIV)
      else $error("divider phase cut short");

endmodule

FILE: sv/dcnt_lane.sv
// One sensor lane: hysteresis occupancy and floor baseline tracking with a
// radix-4 restoring divider. Depends on dcnt_pkg.
module dcnt_lane #(
   parameter int WARMUP_SAMPLES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dcnt_pkg::lane_ctl_type ctl,
   input  logic                  present,
   input  logic                  reading,
   input  logic [15:0]           distance,
   input  logic                  occ_go,     // occupancy phase
   input  logic                  base_go,    // baseline phase
   input  logic                  allow,      // baseline update permitted
   input  logic                  div_step,
   input  logic                  div_last,
   output logic                  occupied,
   output logic                  valid_next
);
   import dcnt_pkg::*;

   localparam logic [3:0] WARM = 4'(WARMUP_SAMPLES);

   logic [23:0] base_ff, base_in;
   logic        valid_ff, valid_in;
   logic [3:0]  samp_ff, samp_in;
   logic        occ_ff, occ_in;
   logic [31:0] num_ff, num_in;
   logic [7:0]  rem_ff, rem_in;
   logic [6:0]  den_ff, den_in;
   logic        dact_ff, dact_in;

   logic        take;
   logic [24:0] lhs;
   logic [31:0] warm_num, slow_num;
   logic [3:0]  n_plus;
   logic [31:0] q;
   logic [7:0]  r;
   logic [8:0]  trial;

   assign take       = allow && present && reading;
   assign valid_next = valid_ff || (take && ctl.kind == KIND_UPDATE && ctl.count_mode);
   assign occupied   = occ_ff;

   // occupancy compare in Q16.8
   assign lhs = {1'b0, distance, 8'd0} +
                {1'b0, (occ_ff ? ctl.release_delta : ctl.trigger_delta), 8'd0};

   // divider numerators
   assign n_plus   = samp_ff + 4'd1;
   assign warm_num = 32'(base_ff * samp_ff) + {8'd0, distance, 8'd0} + 32'(n_plus >> 1);
   assign slow_num = 32'(base_ff * 7'd92) + {5'd0, distance, 11'd0} + 32'd50;

   // two restoring steps per cycle
   always_comb begin
      q = num_ff;
      r = rem_ff;
      for (int k = 0; k < 2; k++) begin
         trial = {r, q[31]} - {2'd0, den_ff};
         q     = {q[30:0], 1'b0};
         if (!trial[8]) begin
            r    = trial[7:0];
            q[0] = 1'b1;
         end else begin
            r = {r[6:0], num_ff[31 - k]};
         end
      end
   end

   always_comb begin
      base_in  = base_ff;
      valid_in = valid_ff;
      samp_in  = samp_ff;
      occ_in   = occ_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dact_in  = dact_ff;
      if (occ_go) begin
         if (ctl.kind == KIND_UPDATE) begin
            if (!ctl.count_mode || !present || !reading || !valid_ff) occ_in = 1'b0;
            else occ_in = (lhs <= {1'b0, base_ff});
         end else if (ctl.kind == KIND_RECAL) begin
            base_in  = '0;
            valid_in = 1'b0;
            samp_in  = '0;
            occ_in   = 1'b0;
         end
      end
      if (base_go && take && ctl.kind == KIND_UPDATE && ctl.count_mode) begin
         if (!valid_ff) begin
            base_in  = {distance, 8'd0};
            valid_in = 1'b1;
            samp_in  = 4'd1;
         end else begin
            dact_in = 1'b1;
            rem_in  = '0;
            if (samp_ff < WARM) begin
               num_in  = warm_num;
               den_in  = {3'd0, n_plus};
               samp_in = n_plus;
            end else begin
               num_in = slow_num;
               den_in = 7'd100;
            end
         end
      end
      if (div_step && dact_ff) begin
         num_in = q;
         rem_in = r;
         if (div_last) begin
            base_in = q[23:0];
            dact_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         valid_ff <= 1'b0;
         samp_ff  <= '0;
         occ_ff   <= 1'b0;
         dact_ff  <= 1'b0;
      end else begin
         base_ff  <= base_in;
         valid_ff <= valid_in;
         samp_ff  <= samp_in;
         occ_ff   <= occ_in;
         dact_ff  <= dact_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

FILE: sv/dcnt_seq.sv
// Merge stage: row activity, crossing sequence machine, counters and the
// result fields. Depends on dcnt_pkg.
module dcnt_seq #(
   parameter int MAX_OCCUPANTS = 50
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  dcnt_pkg::lane_ctl_type ctl,
   input  logic                  invert,
   input  logic [31:0]           timeout,
   input  logic [31:0]           cooldown,
   input  logic [31:0]           now_ms,
   input  logic [3:0]            present,     // already limited to real lanes
   input  logic [3:0]            reading,
   input  logic [3:0]            occ,
   input  logic [3:0]            valid_next,
   output logic                  allow,
   output dcnt_pkg::result_type  result
);
   import dcnt_pkg::*;

   localparam logic [5:0] MAX_PPL = 6'(MAX_OCCUPANTS);

   logic        wait_ff, wait_in, cool_ff, cool_in, both_ff, both_in;
   logic [31:0] dead_ff, dead_in, sst_ff, sst_in, ent_ff, ent_in, exi_ff, exi_in;
   logic [1:0]  start_ff, start_in, last_ff, last_in;
   logic [5:0]  ppl_ff, ppl_in;
   logic [3:0]  ph_ff, ph_in;
   logic [2:0]  dir_ff, dir_in;

   logic        ra, rb, cal, reporting, okseq, a_to_b;
   logic [1:0]  single;

   assign ra        = |(occ[1:0] & present[1:0]);
   assign rb        = |(occ[3:2] & present[3:2]);
   assign single    = (ra && !rb) ? ROW_A : ((!ra && rb) ? ROW_B : ROW_NONE);
   assign reporting = (|present) && ((present & ~reading) == 4'd0);
   assign cal       = ctl.count_mode ? ((|present) && ((present & ~valid_next) == 4'd0))
                                     : reporting;
   assign allow     = !wait_ff && !ra && !rb && start_ff == ROW_NONE;

   // sequence step
   always_comb begin
      wait_in  = wait_ff;  cool_in = cool_ff;  dead_in  = dead_ff;
      start_in = start_ff; last_in = last_ff;  both_in  = both_ff;
      sst_in   = sst_ff;   ent_in  = ent_ff;   exi_in   = exi_ff;
      ppl_in   = ppl_ff;   ph_in   = ph_ff;    dir_in   = dir_ff;
      okseq    = 1'b0;
      a_to_b   = 1'b0;
      if (go) begin
         case (ctl.kind)
            KIND_UPDATE: begin
               if (!ctl.count_mode) begin
                  wait_in = 1'b0; cool_in = 1'b0; dead_in = '0;
                  start_in = ROW_NONE; last_in = ROW_NONE; both_in = 1'b0; sst_in = '0;
                  ph_in  = reporting ? PH_MONITOR : PH_NO_READING;
                  dir_in = DIR_IDLE;
               end else if (!cal) begin
                  ph_in = PH_CALIB;
               end else if (wait_ff) begin
                  ph_in = PH_WAIT_CLEAR;
                  if (!ra && !rb) begin
                     wait_in = 1'b0;
                     ph_in   = PH_READY;
                  end
               end else if (cool_ff && now_ms < dead_ff) begin
                  ph_in = PH_SETTLE;
               end else begin
                  cool_in = 1'b0;
                  dead_in = '0;
                  if (start_ff == ROW_NONE) begin
                     if (single != ROW_NONE) begin
                        start_in = single; last_in = single; both_in = 1'b0;
                        sst_in   = now_ms;
                        ph_in    = (single == ROW_A) ? PH_A_LEAD : PH_B_LEAD;
                     end else if (ra && rb) begin
                        ph_in = PH_BOTH_IDLE;
                     end else begin
                        ph_in = PH_READY;
                     end
                  end else if ((now_ms - sst_ff) > timeout) begin
                     start_in = ROW_NONE; last_in = ROW_NONE; both_in = 1'b0; sst_in = '0;
                     wait_in  = 1'b1;
                     ph_in    = PH_TIMEOUT;
                  end else if (!ra && !rb) begin
                     // doorway clear: close the crossing
                     okseq  = both_ff && start_ff != ROW_NONE && last_ff != ROW_NONE &&
                              start_ff != last_ff;
                     a_to_b = start_ff == ROW_A && last_ff == ROW_B;
                     if (!okseq) begin
                        dir_in = DIR_CANCEL;
                        ph_in  = PH_CANCELLED;
                     end else begin
                        if (a_to_b ^ invert) begin
                           ent_in = ent_ff + 32'd1;
                           if (ppl_ff < MAX_PPL) ppl_in = ppl_ff + 6'd1;
                           dir_in = DIR_ENTRY;
                        end else begin
                           exi_in = exi_ff + 32'd1;
                           if (ppl_ff != 6'd0) ppl_in = ppl_ff - 6'd1;
                           dir_in = DIR_EXIT;
                        end
                        ph_in = PH_COUNTED;
                     end
                     start_in = ROW_NONE; last_in = ROW_NONE; both_in = 1'b0; sst_in = '0;
                     cool_in  = 1'b1;
                     dead_in  = now_ms + cooldown;
                  end else if (ra && rb) begin
                     both_in = 1'b1;
                     ph_in   = PH_BOTH_SEQ;
                  end else begin
                     last_in = single;
                     ph_in   = (single == ROW_A) ? PH_A_ACTIVE : PH_B_ACTIVE;
                  end
               end
            end
            KIND_RECAL: begin
               start_in = ROW_NONE; last_in = ROW_NONE; both_in = 1'b0; sst_in = '0;
               wait_in  = 1'b0; cool_in = 1'b0; dead_in = '0;
               ph_in    = PH_RECAL;
            end
            KIND_CLEAR: begin
               ent_in = '0; exi_in = '0; ppl_in = '0;
               dir_in = DIR_RESET;
            end
            default: ;
         endcase
      end
   end

   // result fields from the post-step state
   always_comb begin
      result.entry_total    = ent_in;
      result.exit_total     = exi_in;
      result.occupants      = ppl_in;
      result.occupied_mask  = occ;
      result.row_a_active   = ctl.count_mode && ra;
      result.row_b_active   = ctl.count_mode && rb;
      result.phase          = ph_in;
      result.last_direction = dir_in;
      result.presence       = ctl.count_mode && (ra || rb || wait_in || start_in != ROW_NONE);
      result.ready_res      = cal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= 1'b0; cool_ff <= 1'b0; dead_ff <= '0;
         start_ff <= ROW_NONE; last_ff <= ROW_NONE; both_ff <= 1'b0; sst_ff <= '0;
         ent_ff <= '0; exi_ff <= '0; ppl_ff <= '0; ph_ff <= PH_RECAL; dir_ff <= DIR_NONE;
      end else begin
         wait_ff <= wait_in; cool_ff <= cool_in; dead_ff <= dead_in;
         start_ff <= start_in; last_ff <= last_in; both_ff <= both_in; sst_ff <= sst_in;
         ent_ff <= ent_in; exi_ff <= exi_in; ppl_ff <= ppl_in; ph_ff <= ph_in;
         dir_ff <= dir_in;
      end
   end

   // occupant count never leaves its range
   assert property (@(posedge clock) disable iff (reset) ppl_ff <= MAX_PPL)
      else $error("occupant count out of range");
   // an open sequence always has a last row recorded
   assert property (@(posedge clock) disable iff (reset)
      start_ff != ROW_NONE |-> last_ff != ROW_NONE)
      else $error("open sequence without last row");
   // waiting for clear never coexists with an open sequence
   assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> start_ff == ROW_NONE)
      else $error("wait-for-clear with open sequence");

endmodule
